[sv/c3vs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3vs_pkg
// Shared types and constants of the 3x3 valid-mode convolution stream unit.
// ----------------------------------------------------------------------------
package c3vs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int KSIZE      = 3;
	localparam int PIX_W      = 16;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 16;
	localparam int KROW_W     = 48;
	localparam int PROD_W     = 2 * PIX_W;
	localparam int CSUM_W     = PROD_W + 2;
	localparam int SUM_W      = 35;
	localparam int MIN_DIM    = 3;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(4);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(4);
	localparam logic [KROW_W-1:0]   KROW_RESET   = 48'hFFFF_0000_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH    = 3'd0,
		CFG_IMAGE_HEIGHT   = 3'd1,
		CFG_KERNEL_ROW_TOP = 3'd2,
		CFG_KERNEL_ROW_MID = 3'd3,
		CFG_KERNEL_ROW_BOT = 3'd4
	} cfg_index_t;

	typedef logic signed [PIX_W-1:0] pix_t;
	typedef logic [KSIZE-1:0][PIX_W-1:0] pix_col_t;

	typedef struct packed {
		logic valid;
		logic emit;
		logic last;
	} tag_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] conv_sum;
		logic                    frame_last;
	} result_t;

endpackage
`default_nettype wire

[sv/c3vs_line_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3vs_line_store
// One image line of pixels, one write port and one registered read port.
// ----------------------------------------------------------------------------
module c3vs_line_store (
	input  wire logic                    clk,
	input  wire logic                    wr_en,
	input  wire logic [c3vs_pkg::COL_W-1:0] wr_addr,
	input  wire logic [c3vs_pkg::PIX_W-1:0] wr_data,
	input  wire logic                    rd_en,
	input  wire logic [c3vs_pkg::COL_W-1:0] rd_addr,
	output logic      [c3vs_pkg::PIX_W-1:0] rd_data
);
	import c3vs_pkg::*;

	logic [PIX_W-1:0] mem_q [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

[sv/c3vs_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3vs_cell
// One window column: holds three pixels, passes them to its left neighbor on
// every shift and forms the registered weighted sum of its column.
// ----------------------------------------------------------------------------
module c3vs_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                shift,
	input  wire c3vs_pkg::pix_col_t  col_in,
	input  wire c3vs_pkg::pix_col_t  coef,
	output c3vs_pkg::pix_col_t       col_out,
	output logic signed [c3vs_pkg::CSUM_W-1:0] col_sum_s4
);
	import c3vs_pkg::*;

	pix_col_t                 col_q;
	logic signed [PROD_W-1:0] prod_s3 [KSIZE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < KSIZE; i++) begin
			prod_s3[i] <= $signed(col_q[i]) * $signed(coef[i]);
		end
		col_sum_s4 <= CSUM_W'(prod_s3[0]) + CSUM_W'(prod_s3[1]) + CSUM_W'(prod_s3[2]);
	end

	assign col_out = col_q;

endmodule
`default_nettype wire

[sv/c3vs_out_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3vs_out_fifo
// Small queue of finished result words in front of the output channel.
// ----------------------------------------------------------------------------
module c3vs_out_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire c3vs_pkg::result_t push_data,
	input  wire logic              pop,
	output logic                   valid,
	output c3vs_pkg::result_t      data
);
	import c3vs_pkg::*;

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;
	logic                 do_pop;

	assign valid  = (count_q != '0);
	assign do_pop = pop && valid;
	assign data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(do_pop);
		end
	end

endmodule
`default_nettype wire

[sv/conv3x3_valid_stream_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_valid_stream_unit
// 3x3 valid-mode, stride-1 correlation over a raster pixel stream.
// ----------------------------------------------------------------------------
// The unit takes one pixel word per clock while the input is ready and gives
// one sum word for every window that lies wholly inside the image, through
// the registered line store read, window shift, nine parallel multiplies and
// column adders; the three column sums are added as the word enters an
// eight-word output queue. The input stays ready as long as accepted pixels
// in flight plus queued words number fewer than eight, so a full-rate sink
// sees no stall. The line stores need no clearing after reset.
// ----------------------------------------------------------------------------
module conv3x3_valid_stream_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [c3vs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [c3vs_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [c3vs_pkg::PIX_W-1:0]    pixel,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [c3vs_pkg::SUM_W-1:0]         conv_sum,
	output logic                                      frame_last
);
	import c3vs_pkg::*;

	logic [WIDTH_W-1:0]             width_q;
	logic [HEIGHT_W-1:0]            height_q;
	logic [KSIZE-1:0][KROW_W-1:0]   kernel_q;
	logic [COL_W-1:0]               col_q;
	logic [HEIGHT_W-1:0]            row_q;
	logic [FIFO_AW:0]               total_q;

	logic [WIDTH_W-1:0]             w_eff;
	logic [HEIGHT_W-1:0]            h_eff;
	logic                           col_wrap;
	logic [COL_W-1:0]               col_eff;
	logic [HEIGHT_W:0]              row_inc;
	logic [HEIGHT_W-1:0]            row_eff;
	logic [WIDTH_W-1:0]             col_next;
	logic [HEIGHT_W:0]              row_next;
	logic                           accept;

	tag_t                           tag_s1, tag_s2, tag_s3, tag_s4;
	pix_t                           px_s1;
	logic [COL_W-1:0]               col_s1;
	logic [PIX_W-1:0]               upper_rd;
	logic [PIX_W-1:0]               lower_rd;

	pix_col_t                       new_col;
	pix_col_t                       cell_in  [KSIZE];
	pix_col_t                       cell_out [KSIZE];
	pix_col_t                       coef_col [KSIZE];
	logic signed [CSUM_W-1:0]       col_sum  [KSIZE];

	logic                           push;
	logic                           retire;
	logic                           pop;
	result_t                        push_data;
	result_t                        head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			kernel_q <= {KROW_RESET, KROW_RESET, KROW_RESET};
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:    width_q     <= cfg_wr_data[WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT:   height_q    <= cfg_wr_data[HEIGHT_W-1:0];
				CFG_KERNEL_ROW_TOP: kernel_q[0] <= cfg_wr_data[KROW_W-1:0];
				CFG_KERNEL_ROW_MID: kernel_q[1] <= cfg_wr_data[KROW_W-1:0];
				CFG_KERNEL_ROW_BOT: kernel_q[2] <= cfg_wr_data[KROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < WIDTH_W'(MIN_DIM)) begin
			w_eff = WIDTH_W'(MIN_DIM);
		end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : height_q;

		col_wrap = ({1'b0, col_q} >= w_eff);
		col_eff  = col_wrap ? '0 : col_q;
		row_inc  = {1'b0, row_q} + (HEIGHT_W+1)'(col_wrap);
		row_eff  = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[HEIGHT_W-1:0];

		col_next = WIDTH_W'(col_eff) + 1'b1;
		row_next = {1'b0, row_eff} + 1'b1;
	end

	assign in_ready = (total_q < (FIFO_AW+1)'(FIFO_DEPTH));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			tag_s1  <= '0;
			tag_s2  <= '0;
			tag_s3  <= '0;
			tag_s4  <= '0;
			total_q <= '0;
		end else begin
			if (accept) begin
				if (col_next >= w_eff) begin
					col_q <= '0;
					row_q <= (row_next >= {1'b0, h_eff}) ? '0 : row_next[HEIGHT_W-1:0];
				end else begin
					col_q <= col_next[COL_W-1:0];
					row_q <= row_eff;
				end
			end
			tag_s1.valid <= accept;
			tag_s1.emit  <= (row_eff >= HEIGHT_W'(2)) && (col_eff >= COL_W'(2));
			tag_s1.last  <= (row_eff == h_eff - 1'b1) && ({1'b0, col_eff} == w_eff - 1'b1);
			tag_s2       <= tag_s1;
			tag_s3       <= tag_s2;
			tag_s4       <= tag_s3;
			total_q      <= total_q + (FIFO_AW+1)'(accept) - (FIFO_AW+1)'(retire)
				- (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1  <= pixel;
			col_s1 <= col_eff;
		end
	end

	c3vs_line_store u_upper (
		.clk     (clk),
		.wr_en   (tag_s1.valid),
		.wr_addr (col_s1),
		.wr_data (lower_rd),
		.rd_en   (accept),
		.rd_addr (col_eff),
		.rd_data (upper_rd)
	);

	c3vs_line_store u_lower (
		.clk     (clk),
		.wr_en   (tag_s1.valid),
		.wr_addr (col_s1),
		.wr_data (px_s1),
		.rd_en   (accept),
		.rd_addr (col_eff),
		.rd_data (lower_rd)
	);

	assign new_col = {px_s1, lower_rd, upper_rd};

	for (genvar j = 0; j < KSIZE; j++) begin : g_cell
		if (j == KSIZE - 1) begin : g_head
			assign cell_in[j] = new_col;
		end else begin : g_link
			assign cell_in[j] = cell_out[j+1];
		end
		for (genvar r = 0; r < KSIZE; r++) begin : g_coef
			assign coef_col[j][r] = kernel_q[r][PIX_W*j +: PIX_W];
		end

		c3vs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (tag_s1.valid),
			.col_in     (cell_in[j]),
			.coef       (coef_col[j]),
			.col_out    (cell_out[j]),
			.col_sum_s4 (col_sum[j])
		);
	end

	assign push   = tag_s4.valid && tag_s4.emit;
	assign retire = tag_s4.valid && !tag_s4.emit;
	assign pop    = out_valid && out_ready;

	assign push_data.conv_sum   = SUM_W'(col_sum[0]) + SUM_W'(col_sum[1]) + SUM_W'(col_sum[2]);
	assign push_data.frame_last = tag_s4.last;

	c3vs_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (out_ready),
		.valid     (out_valid),
		.data      (head)
	);

	assign conv_sum   = head.conv_sum;
	assign frame_last = head.frame_last;

endmodule
`default_nettype wire

[sv/c3vs_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3vs_checker
// Port-level checks of the convolution stream unit, bound to its top level.
// ----------------------------------------------------------------------------
module c3vs_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_ready,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic signed [c3vs_pkg::SUM_W-1:0]    conv_sum,
	input wire logic                                 frame_last
);

	// A waiting result word must hold until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(conv_sum) && $stable(frame_last))
		else $error("result word changed while stalled");

	// With no result queued, the pipeline alone can never fill the credit window.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output queue");

	// A fresh result after an empty queue comes from a pixel taken earlier, through the full pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 5))
		else $error("result word without a matching pixel");

endmodule

bind conv3x3_valid_stream_unit c3vs_checker u_c3vs_checker (.*);
`default_nettype wire
